>>> src/weight_layout_transpose_core_defines.svh
// assertion macros for the weight layout transpose core
// used by the controller and datapath modules; expects clk and rst_n in scope
`ifndef WEIGHT_LAYOUT_TRANSPOSE_CORE_DEFINES_SVH
`define WEIGHT_LAYOUT_TRANSPOSE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define WLT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wlt assertion failed");

`define WLT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wlt assertion failed");

`else

`define WLT_ASSERT_IMP(lbl, ante, cons)

`define WLT_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> src/wlt_pkg.sv
// shared types, constants and helper functions of the weight layout transpose core
// no dependencies
`default_nettype none

package wlt_pkg;

  localparam int MAX_ELEMENTS = 4096;
  localparam int WORD_BITS    = 32;
  localparam int ADDR_BITS    = $clog2(MAX_ELEMENTS);
  localparam int DIM_BITS     = 13;
  localparam int IDX_BITS     = 12;
  localparam int DIM_MAX      = 4096;
  localparam int CMD_BITS     = 2;
  localparam int MODE_BITS    = 2;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_BITS     = DIM_BITS;

  // accumulator saturates at one above capacity
  localparam int ACC_BITS  = $clog2(MAX_ELEMENTS + 2);
  localparam int OPA_BITS  = (ACC_BITS > DIM_BITS) ? ACC_BITS : DIM_BITS;
  localparam int PROD_BITS = OPA_BITS + DIM_BITS;
  localparam int SUM_BITS  = PROD_BITS + 1;

  localparam logic [ACC_BITS-1:0] ACC_MAX = ACC_BITS'(MAX_ELEMENTS);
  localparam logic [ACC_BITS-1:0] ACC_SAT = ACC_BITS'(MAX_ELEMENTS + 1);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_code_t;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_KCRS = 2'd0,
    MODE_CKRS = 2'd1,
    MODE_KC   = 2'd2
  } layout_mode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LAYOUT_MODE = 3'd0,
    REG_DIM_R       = 3'd1,
    REG_DIM_S       = 3'd2,
    REG_DIM_C       = 3'd3,
    REG_DIM_K       = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    MAC_NONE,
    MAC_ADR1,
    MAC_ADR2,
    MAC_ADR3,
    MAC_TOT1,
    MAC_TOT2,
    MAC_TOT3
  } mac_op_t;

  typedef struct packed {
    mac_op_t mac_op;
    logic    accept_wr;
    logic    accept_rd;
    logic    restart;
    logic    store;
    logic    out_load;
    logic    tot_start;
  } wlt_cmd_t;

  typedef struct packed {
    logic stale;
    logic out_free;
  } wlt_stat_t;

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
    logic [DIM_BITS-1:0] res;
    if (v == '0) begin
      res = DIM_BITS'(1);
    end else if (v > DIM_BITS'(DIM_MAX)) begin
      res = DIM_BITS'(DIM_MAX);
    end else begin
      res = v;
    end
    return res;
  endfunction

  function automatic logic [ACC_BITS-1:0] mac_sat(input logic [SUM_BITS-1:0] s);
    logic [ACC_BITS-1:0] res;
    if (s > SUM_BITS'(MAX_ELEMENTS)) begin
      res = ACC_SAT;
    end else begin
      res = s[ACC_BITS-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> src/wlt_in_if.sv
// input item channel of the weight layout transpose core
// depends on wlt_pkg
`default_nettype none

interface wlt_in_if;
  import wlt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CMD_BITS-1:0]  command;
  logic [WORD_BITS-1:0] elem_word;

  modport source (output valid, output command, output elem_word, input ready);
  modport sink (input valid, input command, input elem_word, output ready);
endinterface

`default_nettype wire

>>> src/wlt_out_if.sv
// result item channel of the weight layout transpose core
// depends on wlt_pkg
`default_nettype none

interface wlt_out_if;
  import wlt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] out_word;
  logic                 last_elem;
  logic                 overflow;

  modport source (output valid, output out_word, output last_elem, output overflow,
                  input ready);
  modport sink (input valid, input out_word, input last_elem, input overflow,
                output ready);
endinterface

`default_nettype wire

>>> src/wlt_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module wlt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/wlt_datapath.sv
// datapath: config registers, source counters, address multiply-add unit,
// element buffer and result register; depends on wlt_pkg and wlt_ram
`default_nettype none
`include "weight_layout_transpose_core_defines.svh"

module wlt_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [wlt_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [wlt_pkg::CFG_BITS-1:0]     cfg_data,
  input  wire logic [wlt_pkg::WORD_BITS-1:0]    elem_word,
  input  wire wlt_pkg::wlt_cmd_t               cmd,
  output wlt_pkg::wlt_stat_t                   status,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [wlt_pkg::WORD_BITS-1:0]         out_word,
  output logic                                 last_elem,
  output logic                                 overflow
);
  import wlt_pkg::*;

  layout_mode_t         mode_r, mode_nxt;
  logic [DIM_BITS-1:0]  rdim_r, sdim_r, cdim_r, kdim_r;
  logic [DIM_BITS-1:0]  rdim_nxt, sdim_nxt, cdim_nxt, kdim_nxt;
  logic                 stale_r;
  logic [IDX_BITS-1:0]  ri_r, si_r, ci_r, ki_r;
  logic [IDX_BITS-1:0]  ri_nxt, si_nxt, ci_nxt, ki_nxt;
  logic [ADDR_BITS-1:0] read_pos_r, read_pos_nxt;
  logic [ACC_BITS-1:0]  acc_r, stored_r;
  logic                 over_r;
  logic [WORD_BITS-1:0] wdata_r;
  logic                 last_pend_r, over_pend_r;
  logic                 out_valid_r, out_last_r, out_over_r;
  logic [WORD_BITS-1:0] out_word_r;

  logic                 two_d, mode_ckrs;
  logic [DIM_BITS-1:0]  ext_r, ext_s;
  logic [OPA_BITS-1:0]  mul_a;
  logic [DIM_BITS-1:0]  mul_b;
  logic [IDX_BITS-1:0]  add_x;
  logic [SUM_BITS-1:0]  mac_sum;
  logic [ACC_BITS-1:0]  mac_res;
  logic                 k_wrap, c_wrap, s_wrap, r_wrap;
  logic                 rd_last;
  logic                 ram_we;
  logic [WORD_BITS-1:0] ram_rdata;

  assign two_d     = (mode_r == MODE_KC);
  assign mode_ckrs = (mode_r == MODE_CKRS);
  assign ext_r     = two_d ? DIM_BITS'(1) : rdim_r;
  assign ext_s     = two_d ? DIM_BITS'(1) : sdim_r;

  // config decode
  always_comb begin
    mode_nxt = mode_r;
    rdim_nxt = rdim_r;
    sdim_nxt = sdim_r;
    cdim_nxt = cdim_r;
    kdim_nxt = kdim_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_LAYOUT_MODE: begin
          unique case (cfg_data[MODE_BITS-1:0])
            MODE_CKRS: mode_nxt = MODE_CKRS;
            MODE_KC:   mode_nxt = MODE_KC;
            default:   mode_nxt = MODE_KCRS;
          endcase
        end
        REG_DIM_R: rdim_nxt = clamp_dim(cfg_data);
        REG_DIM_S: sdim_nxt = clamp_dim(cfg_data);
        REG_DIM_C: cdim_nxt = clamp_dim(cfg_data);
        REG_DIM_K: kdim_nxt = clamp_dim(cfg_data);
        default: ;
      endcase
    end
  end

  // shared multiply-add step with saturation above capacity
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    add_x = '0;
    case (cmd.mac_op)
      MAC_ADR1: begin
        mul_a = OPA_BITS'(mode_ckrs ? ci_r : ki_r);
        mul_b = mode_ckrs ? kdim_r : cdim_r;
        add_x = mode_ckrs ? ki_r : ci_r;
      end
      MAC_ADR2: begin
        mul_a = OPA_BITS'(acc_r);
        mul_b = ext_r;
        add_x = two_d ? '0 : ri_r;
      end
      MAC_ADR3: begin
        mul_a = OPA_BITS'(acc_r);
        mul_b = ext_s;
        add_x = two_d ? '0 : si_r;
      end
      MAC_TOT1: begin
        mul_a = OPA_BITS'(ext_r);
        mul_b = ext_s;
      end
      MAC_TOT2: begin
        mul_a = OPA_BITS'(acc_r);
        mul_b = cdim_r;
      end
      MAC_TOT3: begin
        mul_a = OPA_BITS'(acc_r);
        mul_b = kdim_r;
      end
      default: ;
    endcase
    mac_sum = SUM_BITS'(PROD_BITS'(mul_a) * PROD_BITS'(mul_b)) + SUM_BITS'(add_x);
    mac_res = mac_sat(mac_sum);
  end

  // source counters, k fastest
  assign k_wrap = (DIM_BITS'(ki_r) + DIM_BITS'(1)) >= kdim_r;
  assign c_wrap = (DIM_BITS'(ci_r) + DIM_BITS'(1)) >= cdim_r;
  assign s_wrap = (DIM_BITS'(si_r) + DIM_BITS'(1)) >= ext_s;
  assign r_wrap = (DIM_BITS'(ri_r) + DIM_BITS'(1)) >= ext_r;

  always_comb begin
    ki_nxt = ki_r;
    ci_nxt = ci_r;
    si_nxt = si_r;
    ri_nxt = ri_r;
    if (cmd.restart) begin
      ki_nxt = '0;
      ci_nxt = '0;
      si_nxt = '0;
      ri_nxt = '0;
    end else if (cmd.store) begin
      ki_nxt = k_wrap ? '0 : ki_r + IDX_BITS'(1);
      if (k_wrap) begin
        ci_nxt = c_wrap ? '0 : ci_r + IDX_BITS'(1);
        if (c_wrap) begin
          si_nxt = s_wrap ? '0 : si_r + IDX_BITS'(1);
          if (s_wrap) begin
            ri_nxt = r_wrap ? '0 : ri_r + IDX_BITS'(1);
          end
        end
      end
    end
  end

  assign rd_last = (ACC_BITS'(read_pos_r) + ACC_BITS'(1)) >= stored_r;

  always_comb begin
    read_pos_nxt = read_pos_r;
    if (cmd.restart) begin
      read_pos_nxt = '0;
    end else if (cmd.accept_rd) begin
      read_pos_nxt = rd_last ? '0 : read_pos_r + ADDR_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_KCRS;
      rdim_r      <= DIM_BITS'(1);
      sdim_r      <= DIM_BITS'(1);
      cdim_r      <= DIM_BITS'(1);
      kdim_r      <= DIM_BITS'(1);
      stale_r     <= 1'b1;
      ri_r        <= '0;
      si_r        <= '0;
      ci_r        <= '0;
      ki_r        <= '0;
      read_pos_r  <= '0;
      stored_r    <= ACC_BITS'(1);
      over_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      rdim_r     <= rdim_nxt;
      sdim_r     <= sdim_nxt;
      cdim_r     <= cdim_nxt;
      kdim_r     <= kdim_nxt;
      stale_r    <= cfg_we | (stale_r & ~cmd.tot_start);
      ri_r       <= ri_nxt;
      si_r       <= si_nxt;
      ci_r       <= ci_nxt;
      ki_r       <= ki_nxt;
      read_pos_r <= read_pos_nxt;
      if (cmd.mac_op == MAC_TOT3) begin
        over_r   <= (mac_res > ACC_MAX);
        stored_r <= (mac_res > ACC_MAX) ? ACC_MAX : mac_res;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_op != MAC_NONE) begin
      acc_r <= mac_res;
    end
    if (cmd.accept_wr) begin
      wdata_r <= elem_word;
    end
    if (cmd.accept_rd) begin
      last_pend_r <= rd_last;
      over_pend_r <= over_r;
    end
    if (cmd.out_load) begin
      out_word_r <= ram_rdata;
      out_last_r <= last_pend_r;
      out_over_r <= over_pend_r;
    end
  end

  assign ram_we = cmd.store && (acc_r < ACC_MAX);

  wlt_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAX_ELEMENTS)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (acc_r[ADDR_BITS-1:0]),
    .wdata (wdata_r),
    .re    (cmd.accept_rd),
    .raddr (read_pos_r),
    .rdata (ram_rdata)
  );

  assign status.stale    = stale_r;
  assign status.out_free = ~out_valid_r | out_ready;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign last_elem = out_last_r;
  assign overflow  = out_over_r;

  `WLT_ASSERT_IMP(a_stored_range, 1'b1, (stored_r != '0) && (stored_r <= ACC_MAX))
  `WLT_ASSERT_IMP(a_over_full, over_r, stored_r == ACC_MAX)
  `WLT_ASSERT_IMP(a_store_after_addr, cmd.store, $past(cmd.mac_op) == MAC_ADR3)

endmodule

`default_nettype wire

>>> src/wlt_ctrl.sv
// controller state machine: accepts items and sequences address, store,
// read and size recompute steps; depends on wlt_pkg
`default_nettype none
`include "weight_layout_transpose_core_defines.svh"

module wlt_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic [wlt_pkg::CMD_BITS-1:0] in_command,
  output logic                              in_ready,
  input  wire wlt_pkg::wlt_stat_t           status,
  output wlt_pkg::wlt_cmd_t                 cmd
);
  import wlt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_W2,
    S_W3,
    S_WST,
    S_RD,
    S_T2,
    S_T3
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (status.stale) begin
          cmd.tot_start = 1'b1;
          cmd.mac_op    = MAC_TOT1;
          state_nxt     = S_T2;
        end else begin
          in_ready = 1'b1;
          if (in_valid) begin
            unique case (in_command)
              CMD_WRITE: begin
                cmd.accept_wr = 1'b1;
                cmd.mac_op    = MAC_ADR1;
                state_nxt     = S_W2;
              end
              CMD_READ: begin
                cmd.accept_rd = 1'b1;
                state_nxt     = S_RD;
              end
              CMD_RESTART: cmd.restart = 1'b1;
              default: ;
            endcase
          end
        end
      end
      S_W2: begin
        cmd.mac_op = MAC_ADR2;
        state_nxt  = S_W3;
      end
      S_W3: begin
        cmd.mac_op = MAC_ADR3;
        state_nxt  = S_WST;
      end
      S_WST: begin
        cmd.store = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RD: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_T2: begin
        cmd.mac_op = MAC_TOT2;
        state_nxt  = S_T3;
      end
      S_T3: begin
        cmd.mac_op = MAC_TOT3;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `WLT_ASSERT_IMP(a_load_when_free, cmd.out_load, status.out_free)
  `WLT_ASSERT_NXT(a_accept_clears_ready, in_valid && in_ready &&
                  ((in_command == CMD_WRITE) || (in_command == CMD_READ)), !in_ready)

endmodule

`default_nettype wire

>>> src/weight_layout_transpose_core.sv
// Weight layout transpose core. Write items carry 32-bit element words in
// source order (RSCK, or CK in the 2-D mode, K fastest); each word lands in a
// 4096-entry buffer at its KCRS, CKRS or KC address. Read items return the
// buffer in ascending order with a last mark and an overflow flag; restart
// clears the counters. A write runs three multiply-add steps of a
// single shared unit to build the address, then the buffer write; a read
// does a registered buffer read, then waits for the result register to be
// free; restart and unused commands finish on acceptance. After reset and
// after any config write, the tensor size is recomputed on the same unit
// before the next item is taken. A result waiting at the output does not
// block writes or restarts. Depends on wlt_pkg, wlt_in_if, wlt_out_if,
// wlt_ctrl, wlt_datapath and wlt_ram.
`default_nettype none

module weight_layout_transpose_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [wlt_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [wlt_pkg::CFG_BITS-1:0]     cfg_data,
  wlt_in_if.sink                               in_if,
  wlt_out_if.source                            out_if
);
  import wlt_pkg::*;

  wlt_cmd_t  cmd;
  wlt_stat_t status;
  logic      in_ready;

  wlt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_command (in_if.command),
    .in_ready   (in_ready),
    .status     (status),
    .cmd        (cmd)
  );

  wlt_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .elem_word (in_if.elem_word),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_word  (out_if.out_word),
    .last_elem (out_if.last_elem),
    .overflow  (out_if.overflow)
  );

  assign in_if.ready = in_ready;

endmodule

`default_nettype wire
